@@ hdl/slt_pkg.sv @@
package slt_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int OUT_LEN_BITS    = 16;
    localparam int RES_SLOTS       = 3;
    localparam int KW_COUNT        = 4;
    localparam int KW_MAX_LEN      = 5;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_WORD   = 3'd1,
        MODE_NUMBER = 3'd2,
        MODE_STRING = 3'd3,
        MODE_ERROR  = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        EV_VALUE = 2'd0,
        EV_END   = 2'd1,
        EV_ERROR = 2'd2
    } event_t;

    typedef enum logic [2:0] {
        KIND_IDENT   = 3'd0,
        KIND_KEYWORD = 3'd1,
        KIND_NUMBER  = 3'd2,
        KIND_STRING  = 3'd3,
        KIND_SYMBOL  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_UNTERMINATED = 2'd1,
        ERR_UNKNOWN_CHAR = 2'd2
    } err_t;

    typedef struct packed {
        event_t                  ev;
        kind_t                   kind;
        logic [7:0]              value;
        logic [OUT_LEN_BITS-1:0] length;
        err_t                    err;
        logic                    last;
    } result_t;

    // keywords: else, for, if, print
    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
        '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00},
        '{8'h66, 8'h6F, 8'h72, 8'h00, 8'h00},
        '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00},
        '{8'h70, 8'h72, 8'h69, 8'h6E, 8'h74}
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd4, 3'd3, 3'd2, 3'd5};

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    // = + - , { } ( ) [ ] | & !
    function automatic logic is_symbol(input logic [7:0] b);
        return b == 8'h3D || b == 8'h2B || b == 8'h2D || b == 8'h2C ||
               b == 8'h7B || b == 8'h7D || b == 8'h28 || b == 8'h29 ||
               b == 8'h5B || b == 8'h5D || b == 8'h7C || b == 8'h26 ||
               b == 8'h21;
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        if (pos < 3'(KW_MAX_LEN)) begin
            c = KW_TEXT[k][pos];
        end
        return c;
    endfunction

    function automatic result_t make_res(input event_t ev, input kind_t kind,
                                         input logic [7:0] value,
                                         input logic [OUT_LEN_BITS-1:0] length,
                                         input err_t err);
        result_t r;
        r.ev     = ev;
        r.kind   = kind;
        r.value  = value;
        r.length = length;
        r.err    = err;
        r.last   = 1'b0;
        return r;
    endfunction

endpackage

@@ hdl/script_lexer_tokenizer.sv @@
// channel | ports                                              | dir
// --------+----------------------------------------------------+-----
// source  | s_valid s_ready s_source_byte s_end_of_source      | in
// result  | m_valid m_ready m_event_res m_token_kind           | out
//         | m_value_byte m_token_length m_error_code m_last_of_run |
//
// A byte is classified in the cycle it is accepted; its results appear the next cycle.
// Bytes with zero or one result sustain one per clock while m_ready is high; a byte
// with more results holds the source side while the three-entry result queue drains.
// aresetn (synchronous, active low) returns the lexer to idle and empties the queue.
// A stalled result side stops input as soon as any result waits in the queue.
module script_lexer_tokenizer #(
    parameter int LENGTH_BITS = slt_pkg::LENGTH_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_source_byte,
    input  logic        s_end_of_source,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_res,
    output logic [2:0]  m_token_kind,
    output logic [7:0]  m_value_byte,
    output logic [15:0] m_token_length,
    output logic [1:0]  m_error_code,
    output logic        m_last_of_run
);
    import slt_pkg::*;

    result_t    res [RES_SLOTS];
    logic [1:0] res_count;
    logic       accept;
    result_t    head;

    assign accept = s_valid && s_ready;

    slt_lex_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .source_byte   (s_source_byte),
        .end_of_source (s_end_of_source),
        .res_o         (res),
        .res_count     (res_count)
    );

    slt_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept),
        .load_res   (res),
        .load_count (res_count),
        .can_load   (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .head       (head)
    );

    assign m_event_res    = head.ev;
    assign m_token_kind   = head.kind;
    assign m_value_byte   = head.value;
    assign m_token_length = head.length;
    assign m_error_code   = head.err;
    assign m_last_of_run  = head.last;

endmodule

@@ hdl/slt_lex_core.sv @@
module slt_lex_core #(
    parameter int LENGTH_BITS = slt_pkg::LENGTH_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [7:0]        source_byte,
    input  logic              end_of_source,
    output slt_pkg::result_t  res_o [slt_pkg::RES_SLOTS],
    output logic [1:0]        res_count
);
    import slt_pkg::*;

    localparam int EXT_BITS = LENGTH_BITS + OUT_LEN_BITS;
    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

    mode_t                  mode_reg, mode_next;
    logic [KW_COUNT-1:0]    cand_reg, cand_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    result_t                res [RES_SLOTS];
    logic [1:0]             n;
    logic                   do_idle;
    logic                   word_cont;
    kind_t                  fin_kind;

    function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic [OUT_LEN_BITS-1:0] len_out(input logic [LENGTH_BITS-1:0] c);
        logic [EXT_BITS-1:0] ext;
        ext = EXT_BITS'(c);
        return (ext > EXT_BITS'({OUT_LEN_BITS{1'b1}})) ? {OUT_LEN_BITS{1'b1}}
                                                        : ext[OUT_LEN_BITS-1:0];
    endfunction

    // drop every keyword whose next character does not match
    function automatic logic [KW_COUNT-1:0] kw_update(input logic [KW_COUNT-1:0] cand,
                                                      input logic [LENGTH_BITS-1:0] c,
                                                      input logic [7:0] b);
        logic [KW_COUNT-1:0] nc;
        nc = cand;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (!(c < LENGTH_BITS'(KW_LEN[k]) && kw_char(2'(k), c[2:0]) == b)) begin
                nc[k] = 1'b0;
            end
        end
        return nc;
    endfunction

    function automatic kind_t word_kind(input logic [KW_COUNT-1:0] cand,
                                        input logic [LENGTH_BITS-1:0] c);
        kind_t kd;
        kd = KIND_IDENT;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (cand[k] && c == LENGTH_BITS'(KW_LEN[k])) begin
                kd = KIND_KEYWORD;
            end
        end
        return kd;
    endfunction

    assign word_cont = is_letter(source_byte) || is_digit(source_byte) ||
                       source_byte == 8'h2E || source_byte == 8'h5F;

    always_comb begin
        mode_next  = mode_reg;
        cand_next  = cand_reg;
        count_next = count_reg;
        n          = 2'd0;
        do_idle    = 1'b0;
        for (int i = 0; i < RES_SLOTS; i++) begin
            res[i] = make_res(EV_VALUE, KIND_IDENT, 8'h00, '0, ERR_NONE);
        end
        fin_kind = (mode_reg == MODE_WORD) ? word_kind(cand_reg, count_reg) : KIND_NUMBER;

        case (mode_reg)
            MODE_ERROR: begin
            end
            MODE_WORD: begin
                if (word_cont) begin
                    cand_next  = kw_update(cand_reg, count_reg, source_byte);
                    count_next = sat_inc(count_reg);
                    res[0] = make_res(EV_VALUE, KIND_IDENT, source_byte, '0, ERR_NONE);
                    n = 2'd1;
                end else begin
                    res[0] = make_res(EV_END, fin_kind, 8'h00, len_out(count_reg), ERR_NONE);
                    n = 2'd1;
                    do_idle = 1'b1;
                end
            end
            MODE_NUMBER: begin
                if (is_digit(source_byte)) begin
                    count_next = sat_inc(count_reg);
                    res[0] = make_res(EV_VALUE, KIND_NUMBER, source_byte, '0, ERR_NONE);
                    n = 2'd1;
                end else begin
                    res[0] = make_res(EV_END, fin_kind, 8'h00, len_out(count_reg), ERR_NONE);
                    n = 2'd1;
                    do_idle = 1'b1;
                end
            end
            MODE_STRING: begin
                if (source_byte == 8'h22) begin
                    res[0] = make_res(EV_END, KIND_STRING, 8'h00, len_out(count_reg),
                                      ERR_NONE);
                    mode_next = MODE_IDLE;
                end else begin
                    count_next = sat_inc(count_reg);
                    res[0] = make_res(EV_VALUE, KIND_STRING, source_byte, '0, ERR_NONE);
                end
                n = 2'd1;
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        // byte starts fresh; a finished token's end may already sit in slot 0
        if (do_idle) begin
            mode_next  = MODE_IDLE;
            count_next = '0;
            cand_next  = '1;
            if (is_space(source_byte)) begin
            end else if (is_letter(source_byte)) begin
                mode_next  = MODE_WORD;
                cand_next  = kw_update('1, '0, source_byte);
                count_next = LENGTH_BITS'(1);
                res[n] = make_res(EV_VALUE, KIND_IDENT, source_byte, '0, ERR_NONE);
                n = n + 2'd1;
            end else if (is_digit(source_byte)) begin
                mode_next  = MODE_NUMBER;
                count_next = LENGTH_BITS'(1);
                res[n] = make_res(EV_VALUE, KIND_NUMBER, source_byte, '0, ERR_NONE);
                n = n + 2'd1;
            end else if (source_byte == 8'h22) begin
                mode_next = MODE_STRING;
            end else if (is_symbol(source_byte)) begin
                res[n] = make_res(EV_VALUE, KIND_SYMBOL, source_byte, '0, ERR_NONE);
                res[n + 2'd1] = make_res(EV_END, KIND_SYMBOL, 8'h00,
                                         OUT_LEN_BITS'(1), ERR_NONE);
                n = n + 2'd2;
            end else begin
                res[n] = make_res(EV_ERROR, KIND_IDENT, source_byte, '0, ERR_UNKNOWN_CHAR);
                n = n + 2'd1;
                mode_next = MODE_ERROR;
            end
        end

        // close whatever is open at end of source, then back to reset state
        if (end_of_source) begin
            if (mode_next == MODE_WORD || mode_next == MODE_NUMBER) begin
                res[n] = make_res(EV_END,
                                  (mode_next == MODE_WORD) ? word_kind(cand_next, count_next)
                                                           : KIND_NUMBER,
                                  8'h00, len_out(count_next), ERR_NONE);
                n = n + 2'd1;
            end else if (mode_next == MODE_STRING) begin
                res[n] = make_res(EV_ERROR, KIND_STRING, 8'h00, '0, ERR_UNTERMINATED);
                n = n + 2'd1;
            end
            mode_next  = MODE_IDLE;
            count_next = '0;
            cand_next  = '1;
        end

        if (n != 2'd0) begin
            res[n - 2'd1].last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            cand_reg  <= '1;
            count_reg <= '0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            cand_reg  <= cand_next;
            count_reg <= count_next;
        end
    end

    assign res_o     = res;
    assign res_count = n;

`ifndef SYNTHESIS
    a_error_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && mode_reg == MODE_ERROR && !end_of_source) |-> (n == 2'd0))
        else $error("lexer produced results while in error mode");

    a_eos_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && end_of_source) |=> (mode_reg == MODE_IDLE && count_reg == '0 &&
                                       cand_reg == '1))
        else $error("state not cleared after end of source");
`endif

endmodule

@@ hdl/slt_out_queue.sv @@
module slt_out_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  slt_pkg::result_t  load_res [slt_pkg::RES_SLOTS],
    input  logic [1:0]        load_count,
    output logic              can_load,
    output logic              m_valid,
    input  logic              m_ready,
    output slt_pkg::result_t  head
);
    import slt_pkg::*;

    result_t    q_reg [RES_SLOTS];
    result_t    q_next [RES_SLOTS];
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign m_valid  = cnt_reg != 2'd0;
    assign pop      = m_valid && m_ready;
    // a new item may land as the last queued result leaves
    assign can_load = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_ready);
    assign head     = q_reg[0];

    always_comb begin
        q_next   = q_reg;
        cnt_next = cnt_reg;
        if (load) begin
            q_next   = load_res;
            cnt_next = load_count;
        end else if (pop) begin
            for (int i = 0; i < RES_SLOTS - 1; i++) begin
                q_next[i] = q_reg[i + 1];
            end
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
    end

`ifndef SYNTHESIS
    a_last_only_at_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg > 2'd1) |-> !q_reg[0].last)
        else $error("last_of_run set ahead of queued results");

    a_single_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd1) |-> q_reg[0].last)
        else $error("final queued result lacks last_of_run");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop)))
        else $error("queue loaded while results still pending");
`endif

endmodule

@@ tb/script_lexer_tokenizer_chk.sv @@
module script_lexer_tokenizer_chk (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_source_byte,
    input  logic        s_end_of_source,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_event_res,
    input  logic [2:0]  m_token_kind,
    input  logic [7:0]  m_value_byte,
    input  logic [15:0] m_token_length,
    input  logic [1:0]  m_error_code,
    input  logic        m_last_of_run,
    output int          errors,
    output int          due
);
    timeunit 1ns;
    timeprecision 1ps;
    import slt_pkg::*;

    typedef enum logic [2:0] {
        BC_SPACE, BC_ALPHA, BC_DIGIT, BC_QUOTE, BC_PUNCT, BC_JOINER, BC_BAD
    } byte_cls_t;

    string kw_words [4] = '{"else", "for", "if", "print"};

    mode_t       lex_mode;
    logic [3:0]  kw_live;
    logic [15:0] tok_len;
    result_t     step_res[$];
    result_t     token_events_due[$];
    int          fail_total = 0;

    function automatic byte_cls_t classify(input logic [7:0] b);
        byte_cls_t c;
        c = BC_BAD;
        if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) begin
            c = BC_ALPHA;
        end else if (b >= "0" && b <= "9") begin
            c = BC_DIGIT;
        end else if (b == " " || (b >= 8'd9 && b <= 8'd13)) begin
            c = BC_SPACE;
        end else if (b == "\"") begin
            c = BC_QUOTE;
        end else if (b == "." || b == "_") begin
            c = BC_JOINER;
        end else begin
            case (b)
                "=", "+", "-", ",", "{", "}", "(", ")", "[", "]", "|", "&", "!": begin
                    c = BC_PUNCT;
                end
                default: ;
            endcase
        end
        return c;
    endfunction

    function automatic void push_res(input event_t ev, input kind_t kind,
                                     input logic [7:0] v, input logic [15:0] len,
                                     input err_t e);
        result_t r;
        r.ev     = ev;
        r.kind   = kind;
        r.value  = v;
        r.length = len;
        r.err    = e;
        r.last   = 1'b0;
        step_res.push_back(r);
    endfunction

    function automatic void reset_lexer();
        lex_mode = MODE_IDLE;
        kw_live  = 4'hF;
        tok_len  = '0;
    endfunction

    function automatic void bump_len();
        if (tok_len != '1) begin
            tok_len++;
        end
    endfunction

    // drop every keyword whose next letter differs from this one
    function automatic void take_word_byte(input logic [7:0] b);
        for (int k = 0; k < 4; k++) begin
            if (!(tok_len < kw_words[k].len() && kw_words[k][tok_len] == b)) begin
                kw_live[k] = 1'b0;
            end
        end
        bump_len();
        push_res(EV_VALUE, KIND_IDENT, b, '0, ERR_NONE);
    endfunction

    function automatic void close_token();
        kind_t kind;
        kind = KIND_NUMBER;
        if (lex_mode == MODE_WORD) begin
            kind = KIND_IDENT;
            for (int k = 0; k < 4; k++) begin
                if (kw_live[k] && tok_len == kw_words[k].len()) begin
                    kind = KIND_KEYWORD;
                end
            end
        end
        push_res(EV_END, kind, 8'h00, tok_len, ERR_NONE);
        lex_mode = MODE_IDLE;
    endfunction

    function automatic void open_token(input logic [7:0] b);
        reset_lexer();
        case (classify(b))
            BC_SPACE: ;
            BC_ALPHA: begin
                lex_mode = MODE_WORD;
                take_word_byte(b);
            end
            BC_DIGIT: begin
                lex_mode = MODE_NUMBER;
                bump_len();
                push_res(EV_VALUE, KIND_NUMBER, b, '0, ERR_NONE);
            end
            BC_QUOTE: lex_mode = MODE_STRING;
            BC_PUNCT: begin
                push_res(EV_VALUE, KIND_SYMBOL, b, '0, ERR_NONE);
                push_res(EV_END, KIND_SYMBOL, 8'h00, 16'd1, ERR_NONE);
            end
            default: begin
                // '.' and '_' cannot start a token either
                push_res(EV_ERROR, KIND_IDENT, b, '0, ERR_UNKNOWN_CHAR);
                lex_mode = MODE_ERROR;
            end
        endcase
    endfunction

    function automatic void lex_byte(input logic [7:0] b, input logic eos);
        byte_cls_t c;
        c = classify(b);
        step_res.delete();
        case (lex_mode)
            MODE_ERROR: ;
            MODE_WORD: begin
                if (c == BC_ALPHA || c == BC_DIGIT || c == BC_JOINER) begin
                    take_word_byte(b);
                end else begin
                    close_token();
                    open_token(b);
                end
            end
            MODE_NUMBER: begin
                if (c == BC_DIGIT) begin
                    bump_len();
                    push_res(EV_VALUE, KIND_NUMBER, b, '0, ERR_NONE);
                end else begin
                    close_token();
                    open_token(b);
                end
            end
            MODE_STRING: begin
                if (c == BC_QUOTE) begin
                    push_res(EV_END, KIND_STRING, 8'h00, tok_len, ERR_NONE);
                    lex_mode = MODE_IDLE;
                end else begin
                    bump_len();
                    push_res(EV_VALUE, KIND_STRING, b, '0, ERR_NONE);
                end
            end
            default: open_token(b);
        endcase
        if (eos) begin
            if (lex_mode == MODE_WORD || lex_mode == MODE_NUMBER) begin
                close_token();
            end else if (lex_mode == MODE_STRING) begin
                push_res(EV_ERROR, KIND_STRING, 8'h00, '0, ERR_UNTERMINATED);
            end
            reset_lexer();
        end
        if (step_res.size() > 0) begin
            step_res[step_res.size() - 1].last = 1'b1;
        end
        foreach (step_res[i]) begin
            token_events_due.push_back(step_res[i]);
        end
    endfunction

    task automatic report_mismatch(input string what);
        if (fail_total < 40) begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
        fail_total++;
    endtask

    task automatic check_result();
        result_t got;
        result_t want;
        got.ev     = event_t'(m_event_res);
        got.kind   = kind_t'(m_token_kind);
        got.value  = m_value_byte;
        got.length = m_token_length;
        got.err    = err_t'(m_error_code);
        got.last   = m_last_of_run;
        if (token_events_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result ev %0d kind %0d value %02h",
                                      got.ev, got.kind, got.value));
        end else begin
            want = token_events_due.pop_front();
            if (got.ev !== want.ev || got.kind !== want.kind ||
                got.value !== want.value || got.length !== want.length ||
                got.err !== want.err || got.last !== want.last) begin
                report_mismatch($sformatf(
                    "exp/got ev %0d/%0d kind %0d/%0d value %02h/%02h len %0d/%0d err %0d/%0d last %0d/%0d",
                    want.ev, got.ev, want.kind, got.kind, want.value, got.value,
                    want.length, got.length, want.err, got.err, want.last, got.last));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_lexer();
            token_events_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                check_result();
            end
            if (s_valid && s_ready) begin
                lex_byte(s_source_byte, s_end_of_source);
            end
        end
        errors <= fail_total;
        due    <= token_events_due.size();
    end

endmodule

@@ tb/script_lexer_tokenizer_tb.sv @@
module script_lexer_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_source_byte = 8'h00;
    logic        s_end_of_source = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_event_res;
    logic [2:0]  m_token_kind;
    logic [7:0]  m_value_byte;
    logic [15:0] m_token_length;
    logic [1:0]  m_error_code;
    logic        m_last_of_run;

    int   fails;
    int   due;
    int   send_idle = 0;
    int   stall_pct = 0;
    logic hold_off = 1'b0;
    bit   pressure_go = 1'b0;

    string key_words [4] = '{"else", "for", "if", "print"};

    script_lexer_tokenizer i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_source_byte   (s_source_byte),
        .s_end_of_source (s_end_of_source),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res),
        .m_token_kind    (m_token_kind),
        .m_value_byte    (m_value_byte),
        .m_token_length  (m_token_length),
        .m_error_code    (m_error_code),
        .m_last_of_run   (m_last_of_run)
    );

    script_lexer_tokenizer_chk i_chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_source_byte   (s_source_byte),
        .s_end_of_source (s_end_of_source),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_res     (m_event_res),
        .m_token_kind    (m_token_kind),
        .m_value_byte    (m_value_byte),
        .m_token_length  (m_token_length),
        .m_error_code    (m_error_code),
        .m_last_of_run   (m_last_of_run),
        .errors          (fails),
        .due             (due)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        m_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    // long result-side stall so the result queue fills and input backs up
    initial begin
        wait (pressure_go);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (400) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [7:0] pick_letter();
        return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
    endfunction

    function automatic logic [7:0] pick_word_byte();
        logic [7:0] b;
        case ($urandom_range(9))
            0: b = ".";
            1: b = "_";
            2, 3: b = 8'("0" + $urandom_range(9));
            default: b = pick_letter();
        endcase
        return b;
    endfunction

    function automatic logic [7:0] pick_space();
        return $urandom_range(1) ? 8'h20 : 8'($urandom_range(13, 9));
    endfunction

    function automatic logic [7:0] pick_string_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (b == 8'h22) begin
            b = 8'($urandom_range(255));
        end
        return b;
    endfunction

    function automatic logic [7:0] pick_bad_byte();
        string odd = "#$%*/;<>?@^~:";
        logic [7:0] b;
        case ($urandom_range(2))
            0: b = 8'($urandom_range(255, 128));
            1: b = 8'($urandom_range(8));
            default: b = odd[$urandom_range(odd.len() - 1)];
        endcase
        return b;
    endfunction

    task automatic send_src(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_source_byte   <= b;
        s_end_of_source <= eos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // one source text of random tokens, closed by end of source
    task automatic random_source(inout int counted);
        logic [7:0] src[$];
        string      kw;
        int         n;
        int         pick;
        int         live;
        bit         broken;
        string      syms = "=+-,{}()[]|&!";
        broken = 1'b0;
        live   = -1;
        for (int t = 0; t < $urandom_range(6, 1) && !broken; t++) begin
            pick = $urandom_range(99);
            if (pick < 22) begin
                kw = key_words[$urandom_range(3)];
                n  = kw.len();
                if ($urandom_range(3) == 0) n--;
                for (int i = 0; i < n; i++) src.push_back(kw[i]);
                if ($urandom_range(3) == 0) src.push_back(pick_word_byte());
            end else if (pick < 40) begin
                src.push_back(pick_letter());
                repeat ($urandom_range(6)) src.push_back(pick_word_byte());
            end else if (pick < 55) begin
                repeat ($urandom_range(5, 1)) src.push_back(8'("0" + $urandom_range(9)));
            end else if (pick < 72) begin
                src.push_back(8'h22);
                repeat ($urandom_range(6)) src.push_back(pick_string_byte());
                if ($urandom_range(9) != 0) begin
                    src.push_back(8'h22);
                end else begin
                    broken = 1'b1;
                end
            end else if (pick < 87) begin
                src.push_back(syms[$urandom_range(12)]);
            end else if (pick < 95) begin
                src.push_back(8'($urandom_range(255)));
            end else begin
                src.push_back(pick_bad_byte());
                live = src.size();
                // trailing bytes are swallowed until end of source
                repeat ($urandom_range(3)) src.push_back(8'($urandom_range(255)));
                broken = 1'b1;
            end
            if (!broken && $urandom_range(2) != 0) src.push_back(pick_space());
        end
        if (live < 0) live = src.size();
        foreach (src[i]) begin
            send_src(src[i], i == src.size() - 1);
        end
        counted += live;
    endtask

    initial begin
        int counted;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // keyword cut by a symbol
        send_src("i", 1'b0);
        send_src("f", 1'b0);
        send_src("(", 1'b0);
        // string holding NUL and 0xFF
        send_src(8'h22, 1'b0);
        send_src(8'h00, 1'b0);
        send_src(8'hFF, 1'b0);
        send_src(8'h22, 1'b0);
        // number cut by a letter, word cut by tab
        send_src("9", 1'b0);
        send_src("0", 1'b0);
        send_src("a", 1'b0);
        send_src(8'h09, 1'b0);
        // open quote at end of source
        send_src(8'h22, 1'b1);
        // unknown char, then ignored bytes
        send_src("#", 1'b0);
        send_src("x", 1'b0);
        send_src(8'h00, 1'b1);
        send_src(8'h00, 1'b0);
        send_src("z", 1'b1);
        send_src("]", 1'b1);
        send_src("p", 1'b0);
        send_src("r", 1'b0);
        send_src("i", 1'b0);
        send_src("n", 1'b0);
        send_src("t", 1'b1);
        // word cut by an unknown char
        send_src("e", 1'b0);
        send_src(8'h7F, 1'b0);
        send_src(" ", 1'b1);

        pressure_go = 1'b1;
        counted = 0;
        while (counted < 56) random_source(counted);

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    send_idle = 81;
                    stall_pct <= 0;
                end
                1: begin
                    send_idle = 0;
                    stall_pct <= 81;
                end
                default: begin
                    send_idle = 23;
                    stall_pct <= 23;
                end
            endcase
            counted = 0;
            while (counted < 56) random_source(counted);
        end
        s_valid <= 1'b0;

        repeat (2) @(posedge aclk);
        while (due != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fails == 0 && due == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ script_lexer_tokenizer.f @@
hdl/slt_pkg.sv
hdl/slt_lex_core.sv
hdl/slt_out_queue.sv
hdl/script_lexer_tokenizer.sv
tb/script_lexer_tokenizer_chk.sv
tb/script_lexer_tokenizer_tb.sv
